### rtl/dmwbc_pkg.sv
`default_nettype none
package dmwbc_pkg;

    localparam int ADDR_W      = 32;
    localparam int DATA_W      = 32;
    localparam int LINE_BYTE_W = 4;
    localparam int WORD_BITS   = 2;
    localparam int LAT_W       = 4;
    localparam int CYCLES_W    = 6;
    localparam int COUNT_W     = 32;

    localparam logic [LAT_W-1:0] LAT_RESET = 4'd3;

    // request kinds
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic load_req;
        logic lookup;
        logic fill_step;
        logic respond;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic hit;
        logic fill_done;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

### rtl/dmwbc_req_if.sv
`default_nettype none
interface dmwbc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [dmwbc_pkg::ADDR_W-1:0]  address;
    logic [dmwbc_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, action, address, write_data, input ready);
    modport sink   (input valid, action, address, write_data, output ready);
endinterface
`default_nettype wire

### rtl/dmwbc_rsp_if.sv
`default_nettype none
interface dmwbc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [dmwbc_pkg::DATA_W-1:0]    read_data;
    logic                            was_hit;
    logic                            did_writeback;
    logic [dmwbc_pkg::CYCLES_W-1:0]  modeled_cycles;
    logic [dmwbc_pkg::COUNT_W-1:0]   hit_total;
    logic [dmwbc_pkg::COUNT_W-1:0]   miss_total;
    logic [dmwbc_pkg::COUNT_W-1:0]   writeback_total;

    modport source (output valid, read_data, was_hit, did_writeback, modeled_cycles,
                    hit_total, miss_total, writeback_total, input ready);
    modport sink   (input valid, read_data, was_hit, did_writeback, modeled_cycles,
                    hit_total, miss_total, writeback_total, output ready);
endinterface
`default_nettype wire

### rtl/dmwbc_cfg_if.sv
`default_nettype none
interface dmwbc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dmwbc_pkg::LAT_W-1:0]   memory_latency;

    modport source (output valid, memory_latency, input ready);
    modport sink   (input valid, memory_latency, output ready);
endinterface
`default_nettype wire

### rtl/direct_mapped_writeback_cache.sv
// Direct-mapped, write-back, write-allocate cache with 2**LINE_INDEX_BITS lines of four
// 32-bit words. Each request transfer is a read or a write of one word; each gives exactly
// one result transfer with the read word (zero for writes), hit and write-back flags, the
// modelled cycle cost (2 hit, L+3 clean miss, 2L+3 dirty miss, L = memory_latency with 0
// taken as 1) and saturating hit/miss/write-back totals. After reset a clearing pass walks
// the tag store, one line per cycle, clearing all 2**LINE_INDEX_BITS lines (1024 by default);
// no request is taken until it ends, though memory_latency writes are. One request is in
// flight at a time: a hit goes through tag/data read, compare and result load before the next
// request is taken, a miss also through a line refill of four words through the single write
// port of the data store. The result sits in an output register, so a stalled result holds
// until it is taken, and the next result waits in the controller until the register is free.
`default_nettype none
module direct_mapped_writeback_cache #(
    parameter int LINE_INDEX_BITS = 10
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    dmwbc_req_if.sink  i_req,
    dmwbc_rsp_if.source o_rsp,
    dmwbc_cfg_if.sink  i_cfg
);

    dmwbc_pkg::t_ctrl_cmd  cmd;
    dmwbc_pkg::t_dp_status status;
    logic                  req_ready;

    // latency register always takes a transfer
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = req_ready;

    // sequencing: clear pass, lookup, refill, result hand-off
    dmwbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_req_ready (req_ready)
    );

    // tag and data stores, counters, result register
    dmwbc_dp #(
        .LINE_INDEX_BITS (LINE_INDEX_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_action          (i_req.action),
        .i_address         (i_req.address),
        .i_write_data      (i_req.write_data),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_latency     (i_cfg.memory_latency),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_valid       (o_rsp.valid),
        .o_read_data       (o_rsp.read_data),
        .o_was_hit         (o_rsp.was_hit),
        .o_did_writeback   (o_rsp.did_writeback),
        .o_modeled_cycles  (o_rsp.modeled_cycles),
        .o_hit_total       (o_rsp.hit_total),
        .o_miss_total      (o_rsp.miss_total),
        .o_writeback_total (o_rsp.writeback_total)
    );

endmodule
`default_nettype wire

### rtl/dmwbc_ctrl.sv
`default_nettype none
module dmwbc_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_req_valid,
    input  dmwbc_pkg::t_dp_status  i_status,
    output dmwbc_pkg::t_ctrl_cmd   o_cmd,
    output logic                   o_req_ready
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOKUP = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = i_status.hit ? ST_RESP : ST_FILL;
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.respond = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_req_ready = (r_state == ST_IDLE);

endmodule
`default_nettype wire

### rtl/dmwbc_dp.sv
`default_nettype none
module dmwbc_dp #(
    parameter int LINE_INDEX_BITS = 10
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  dmwbc_pkg::t_ctrl_cmd                 i_cmd,
    output dmwbc_pkg::t_dp_status                o_status,
    input  wire                                  i_action,
    input  wire  [dmwbc_pkg::ADDR_W-1:0]         i_address,
    input  wire  [dmwbc_pkg::DATA_W-1:0]         i_write_data,
    input  wire                                  i_cfg_valid,
    input  wire  [dmwbc_pkg::LAT_W-1:0]          i_cfg_latency,
    input  wire                                  i_rsp_ready,
    output logic                                 o_rsp_valid,
    output logic [dmwbc_pkg::DATA_W-1:0]         o_read_data,
    output logic                                 o_was_hit,
    output logic                                 o_did_writeback,
    output logic [dmwbc_pkg::CYCLES_W-1:0]       o_modeled_cycles,
    output logic [dmwbc_pkg::COUNT_W-1:0]        o_hit_total,
    output logic [dmwbc_pkg::COUNT_W-1:0]        o_miss_total,
    output logic [dmwbc_pkg::COUNT_W-1:0]        o_writeback_total
);

    localparam int LINE_COUNT = 1 << LINE_INDEX_BITS;
    localparam int TAG_W      = dmwbc_pkg::ADDR_W - dmwbc_pkg::LINE_BYTE_W - LINE_INDEX_BITS;
    localparam int ENTRY_W    = TAG_W + 2;
    localparam int DADDR_W    = LINE_INDEX_BITS + dmwbc_pkg::WORD_BITS;
    localparam int WORDS      = LINE_COUNT << dmwbc_pkg::WORD_BITS;
    localparam int BASE_W     = dmwbc_pkg::ADDR_W - dmwbc_pkg::LINE_BYTE_W;
    localparam int WADDR_W    = dmwbc_pkg::ADDR_W - dmwbc_pkg::WORD_BITS;

    function automatic logic [dmwbc_pkg::COUNT_W-1:0] f_sat_inc(
        input logic [dmwbc_pkg::COUNT_W-1:0] v
    );
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // tag store entry: {valid, dirty, tag}
    logic [ENTRY_W-1:0]                 tag_mem [LINE_COUNT];
    logic [dmwbc_pkg::DATA_W-1:0]       data_mem [WORDS];

    logic                               r_action;
    logic [dmwbc_pkg::ADDR_W-1:0]       r_addr;
    logic [dmwbc_pkg::DATA_W-1:0]       r_wdata;
    logic [ENTRY_W-1:0]                 r_entry;
    logic [dmwbc_pkg::DATA_W-1:0]       r_word;
    logic [LINE_INDEX_BITS-1:0]         r_clr;
    logic [dmwbc_pkg::WORD_BITS-1:0]    r_fill;
    logic [dmwbc_pkg::LAT_W-1:0]        r_latency;
    logic [dmwbc_pkg::COUNT_W-1:0]      r_hits;
    logic [dmwbc_pkg::COUNT_W-1:0]      r_misses;
    logic [dmwbc_pkg::COUNT_W-1:0]      r_wbs;
    logic [dmwbc_pkg::DATA_W-1:0]       r_res_rdata;
    logic                               r_res_hit;
    logic                               r_res_wb;
    logic [dmwbc_pkg::CYCLES_W-1:0]     r_res_cycles;
    logic                               r_rsp_valid;

    logic [LINE_INDEX_BITS-1:0]         in_index;
    logic [LINE_INDEX_BITS-1:0]         req_index;
    logic [TAG_W-1:0]                   req_tag;
    logic [dmwbc_pkg::WORD_BITS-1:0]    req_word;
    logic                               is_write;
    logic                               hit;
    logic                               wb;
    logic                               tag_we;
    logic [LINE_INDEX_BITS-1:0]         tag_waddr;
    logic [ENTRY_W-1:0]                 tag_wdata;
    logic                               data_we;
    logic [DADDR_W-1:0]                 data_waddr;
    logic [dmwbc_pkg::DATA_W-1:0]       data_wdata;
    logic [dmwbc_pkg::CYCLES_W-1:0]     lat_eff;
    logic [dmwbc_pkg::CYCLES_W-1:0]     cycles;

    assign in_index  = i_address[dmwbc_pkg::LINE_BYTE_W +: LINE_INDEX_BITS];
    assign req_index = r_addr[dmwbc_pkg::LINE_BYTE_W +: LINE_INDEX_BITS];
    assign req_tag   = r_addr[dmwbc_pkg::ADDR_W-1 -: TAG_W];
    assign req_word  = r_addr[dmwbc_pkg::WORD_BITS +: dmwbc_pkg::WORD_BITS];
    assign is_write  = (r_action == dmwbc_pkg::ACT_WRITE);

    assign hit = r_entry[ENTRY_W-1] && (r_entry[TAG_W-1:0] == req_tag);
    assign wb  = r_entry[ENTRY_W-1] && r_entry[ENTRY_W-2] && !hit;

    // memory write ports
    always_comb begin
        tag_we    = i_cmd.clear_step || (i_cmd.lookup && (!hit || is_write));
        tag_waddr = i_cmd.clear_step ? r_clr : req_index;
        tag_wdata = i_cmd.clear_step ? '0 : {1'b1, is_write, req_tag};

        data_we    = i_cmd.fill_step || (i_cmd.lookup && hit && is_write);
        data_waddr = {req_index, i_cmd.fill_step ? r_fill : req_word};
        if (i_cmd.fill_step && !(is_write && (r_fill == req_word))) begin
            // refill pattern: block base plus word offset
            data_wdata = {r_addr[dmwbc_pkg::ADDR_W-1 -: BASE_W], r_fill,
                          {dmwbc_pkg::WORD_BITS{1'b0}}};
        end else begin
            data_wdata = r_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (i_cmd.load_req) begin
            r_entry <= tag_mem[in_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (i_cmd.load_req) begin
            r_word <= data_mem[{in_index,
                                i_address[dmwbc_pkg::WORD_BITS +: dmwbc_pkg::WORD_BITS]}];
        end
    end

    // a zero latency setting is taken as the least nonzero setting
    assign lat_eff = (r_latency == '0) ? dmwbc_pkg::CYCLES_W'(1)
                                       : dmwbc_pkg::CYCLES_W'(r_latency);
    assign cycles  = dmwbc_pkg::CYCLES_W'(2)
                   + (hit ? '0 : lat_eff + dmwbc_pkg::CYCLES_W'(1))
                   + (wb ? lat_eff : '0);

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_action <= i_action;
            r_addr   <= i_address;
            r_wdata  <= i_write_data;
        end
        if (i_cmd.lookup) begin
            if (is_write) begin
                r_res_rdata <= '0;
            end else if (hit) begin
                r_res_rdata <= r_word;
            end else begin
                r_res_rdata <= {r_addr[dmwbc_pkg::ADDR_W-1 -: WADDR_W],
                                {dmwbc_pkg::WORD_BITS{1'b0}}};
            end
            r_res_hit    <= hit;
            r_res_wb     <= wb;
            r_res_cycles <= cycles;
        end
        if (i_cmd.respond) begin
            o_read_data       <= r_res_rdata;
            o_was_hit         <= r_res_hit;
            o_did_writeback   <= r_res_wb;
            o_modeled_cycles  <= r_res_cycles;
            o_hit_total       <= r_hits;
            o_miss_total      <= r_misses;
            o_writeback_total <= r_wbs;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_fill      <= '0;
            r_latency   <= dmwbc_pkg::LAT_RESET;
            r_hits      <= '0;
            r_misses    <= '0;
            r_wbs       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.lookup) begin
                r_fill <= '0;
            end else if (i_cmd.fill_step) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cfg_valid) begin
                r_latency <= i_cfg_latency;
            end
            if (i_cmd.lookup) begin
                if (hit) begin
                    r_hits <= f_sat_inc(r_hits);
                end else begin
                    r_misses <= f_sat_inc(r_misses);
                end
                if (wb) begin
                    r_wbs <= f_sat_inc(r_wbs);
                end
            end
            if (i_cmd.respond) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid         = r_rsp_valid;
    assign o_status.clear_done = (r_clr == LINE_INDEX_BITS'(LINE_COUNT - 1));
    assign o_status.hit        = hit;
    assign o_status.fill_done  = (r_fill == '1);
    assign o_status.out_free   = !r_rsp_valid || i_rsp_ready;

endmodule
`default_nettype wire
